// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion helpers, compiled out for synthesis
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/bdlp_pkg.sv =====
package bdlp_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int TIME_W      = 63;
  localparam int DBN_W       = 20;
  localparam int LONG_W      = 24;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FITTED    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LONGPRESS = CFG_IDX_W'(3);

  // reset values
  localparam logic [NUM_BUTTONS-1:0] FITTED_RST    = NUM_BUTTONS'(3);
  localparam logic [NUM_BUTTONS-1:0] POLARITY_RST  = NUM_BUTTONS'(0);
  localparam logic [DBN_W-1:0]       DEBOUNCE_RST  = DBN_W'(25000);
  localparam logic [LONG_W-1:0]      LONGPRESS_RST = LONG_W'(600000);

  typedef struct packed {
    logic press;
    logic long_ev;
    logic held;
  } lane_result_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] press_events;
    logic [NUM_BUTTONS-1:0] long_events;
    logic [NUM_BUTTONS-1:0] held_mask;
  } result_t;

endpackage

// ===== src/bdlp_if.sv =====
// poll channel
interface bdlp_poll_if;
  logic                               valid;
  logic                               ready;
  logic [bdlp_pkg::NUM_BUTTONS-1:0]   pin_levels;
  logic [bdlp_pkg::TIME_W-1:0]        now_us;

  modport source (output valid, output pin_levels, output now_us, input ready);
  modport sink   (input valid, input pin_levels, input now_us, output ready);
endinterface

// result channel
interface bdlp_result_if;
  logic                               valid;
  logic                               ready;
  logic [bdlp_pkg::NUM_BUTTONS-1:0]   press_events;
  logic [bdlp_pkg::NUM_BUTTONS-1:0]   long_events;
  logic [bdlp_pkg::NUM_BUTTONS-1:0]   held_mask;

  modport source (output valid, output press_events, output long_events,
                  output held_mask, input ready);
  modport sink   (input valid, input press_events, input long_events,
                  input held_mask, output ready);
endinterface

// register write channel
interface bdlp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bdlp_pkg::CFG_IDX_W-1:0]     index;
  logic [bdlp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/button_debounce_long_press.sv =====
// channel   dir  handshake       payload
// poll_ch   in   valid / ready   pin_levels, now_us
// result_ch out  valid / ready   press_events, long_events, held_mask
// cfg_ch    in   valid / ready   index, data
//
// one poll per cycle while the result buffer has room; the result is registered
// every button has its own lane, all lanes settle a poll in the same cycle
// the worst path is one 64-bit add and compare of a stored time stamp per lane
// a two-entry result buffer lets polls keep coming while one result waits
// rst is synchronous: registers go to their reset values, lane state clears
// cfg_ch is always ready, writes to unknown indexes are dropped
module button_debounce_long_press (
  input  logic    clk,
  input  logic    rst,
  bdlp_poll_if.sink     poll_ch,
  bdlp_result_if.source result_ch,
  bdlp_cfg_if.sink      cfg_ch
);

  // configuration registers
  logic [bdlp_pkg::NUM_BUTTONS-1:0] fitted_mask;
  logic [bdlp_pkg::NUM_BUTTONS-1:0] pressed_level_mask;
  logic [bdlp_pkg::DBN_W-1:0]       debounce_us;
  logic [bdlp_pkg::LONG_W-1:0]      long_press_us;

  logic                   poll_take;
  logic                   buf_ready;
  bdlp_pkg::lane_result_t lane_res [bdlp_pkg::NUM_BUTTONS];
  bdlp_pkg::result_t      res_data;

  assign cfg_ch.ready  = 1'b1;
  assign poll_ch.ready = buf_ready;
  assign poll_take     = poll_ch.valid && buf_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fitted_mask        <= bdlp_pkg::FITTED_RST;
      pressed_level_mask <= bdlp_pkg::POLARITY_RST;
      debounce_us        <= bdlp_pkg::DEBOUNCE_RST;
      long_press_us      <= bdlp_pkg::LONGPRESS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bdlp_pkg::REG_FITTED: begin
          fitted_mask <= cfg_ch.data[bdlp_pkg::NUM_BUTTONS-1:0];
        end
        bdlp_pkg::REG_POLARITY: begin
          pressed_level_mask <= cfg_ch.data[bdlp_pkg::NUM_BUTTONS-1:0];
        end
        bdlp_pkg::REG_DEBOUNCE: begin
          debounce_us <= cfg_ch.data[bdlp_pkg::DBN_W-1:0];
        end
        bdlp_pkg::REG_LONGPRESS: begin
          long_press_us <= cfg_ch.data[bdlp_pkg::LONG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // one lane per button, debounce and long-press check side by side
  for (genvar i = 0; i < bdlp_pkg::NUM_BUTTONS; i++) begin : g_lane
    bdlp_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .take          (poll_take),
      .fitted        (fitted_mask[i]),
      .polarity      (pressed_level_mask[i]),
      .level         (poll_ch.pin_levels[i]),
      .now_us        (poll_ch.now_us),
      .debounce_us   (debounce_us),
      .long_press_us (long_press_us),
      .res           (lane_res[i])
    );
  end

  // merge lane flags into one result transaction and buffer it
  bdlp_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (poll_take),
    .push_ready (buf_ready),
    .lane_res   (lane_res),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_data   (res_data)
  );

  assign result_ch.press_events = res_data.press_events;
  assign result_ch.long_events  = res_data.long_events;
  assign result_ch.held_mask    = res_data.held_mask;

endmodule

// ===== src/bdlp_lane.sv =====
`include "assert_macros.svh"

module bdlp_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic                            fitted,
  input  logic                            polarity,
  input  logic                            level,
  input  logic [bdlp_pkg::TIME_W-1:0]     now_us,
  input  logic [bdlp_pkg::DBN_W-1:0]      debounce_us,
  input  logic [bdlp_pkg::LONG_W-1:0]     long_press_us,
  output bdlp_pkg::lane_result_t          res
);

  logic                        last_raw;
  logic                        stable_state;
  logic [bdlp_pkg::TIME_W-1:0] change_time;
  logic [bdlp_pkg::TIME_W-1:0] press_time;
  logic                        long_done;

  logic pressed;
  logic changed;
  logic settle_ok;
  logic hold_ok;
  logic long_zero;
  logic accept;
  logic stable_next;
  logic long_done_next;

  assign pressed   = (level == polarity);
  assign changed   = (pressed != last_raw);
  assign long_zero = (long_press_us == '0);

  // elapsed >= threshold, elapsed clamped at zero when time runs backwards
  assign settle_ok = (debounce_us == '0) ||
                     ({1'b0, now_us} >= ({1'b0, change_time} + 64'(debounce_us)));
  assign hold_ok   = long_zero ||
                     ({1'b0, now_us} >= ({1'b0, press_time} + 64'(long_press_us)));

  assign accept         = fitted && !changed && (pressed != stable_state) && settle_ok;
  assign stable_next    = accept ? pressed : stable_state;
  assign long_done_next = (accept && pressed) ? 1'b0 : long_done;

  always_comb begin
    res.press   = accept && pressed;
    res.held    = fitted && stable_next;
    res.long_ev = fitted && stable_next && !long_done_next &&
                  ((accept && pressed) ? long_zero : hold_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      stable_state <= 1'b0;
      change_time  <= '0;
      press_time   <= '0;
      long_done    <= 1'b0;
    end else if (take && fitted) begin
      if (changed) begin
        last_raw    <= pressed;
        change_time <= now_us;
      end else if (accept) begin
        stable_state <= pressed;
        if (pressed) begin
          press_time <= now_us;
        end
      end
      long_done <= long_done_next || res.long_ev;
    end
  end

  `ASSERT_CLK(a_press_sets_stable, clk, rst, (take && res.press) |=> stable_state, "press without stable state")
  `ASSERT_CLK(a_long_sets_done, clk, rst, (take && res.long_ev) |=> long_done, "long event not recorded")
  `ASSERT_CLK(a_idle_keeps_state, clk, rst, !take |=> ($stable(stable_state) && $stable(last_raw)), "state moved without poll")

endmodule

// ===== src/bdlp_merge.sv =====
`include "assert_macros.svh"

module bdlp_merge (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    push_ready,
  input  bdlp_pkg::lane_result_t  lane_res [bdlp_pkg::NUM_BUTTONS],
  output logic                    out_valid,
  input  logic                    out_ready,
  output bdlp_pkg::result_t       out_data
);

  bdlp_pkg::result_t merged;
  bdlp_pkg::result_t slot0;
  bdlp_pkg::result_t slot1;
  logic [1:0]        count;
  logic              pop;

  // gather per-lane flags into masks
  always_comb begin
    merged = '0;
    for (int i = 0; i < bdlp_pkg::NUM_BUTTONS; i++) begin
      merged.press_events[i] = lane_res[i].press;
      merged.long_events[i]  = lane_res[i].long_ev;
      merged.held_mask[i]    = lane_res[i].held;
    end
  end

  assign push_ready = (count != 2'd2);
  assign out_valid  = (count != 2'd0);
  assign out_data   = slot0;
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // head plus skid slot
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        slot0 <= merged;
      end else begin
        slot0 <= slot1;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= merged;
      end else begin
        slot1 <= merged;
      end
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, (count == 2'd2) |-> !push_ready, "push into full buffer")
  `ASSERT_CLK(a_fill, clk, rst, (push && !pop && count == 2'd1) |=> (count == 2'd2), "fill lost")
  `ASSERT_CLK(a_drain, clk, rst, (pop && !push) |=> (count == $past(count) - 2'd1), "drain miscounted")

endmodule
